// ===== src/aehg_pkg.sv =====
// package for the acoustic emission hit grader
// holds widths, limits and register index codes; no dependencies
package aehg_pkg;

  localparam int unsigned AMP_W     = 7;
  localparam int unsigned CNT_W     = 32;
  localparam int unsigned DUR_W     = 48;
  localparam int unsigned HIST_W    = 24;
  localparam int unsigned SLOT_W    = 4;

  localparam int unsigned HOLD_PERIODS = 8;
  localparam int unsigned HOLD_AW      = 3;
  localparam int unsigned TOP_COUNT    = 10;
  localparam int unsigned TOP_CW       = 4;
  localparam int unsigned RING_DEPTH   = 256;
  localparam int unsigned RING_AW      = 8;
  localparam int unsigned WIN_W        = 8;

  localparam int unsigned SHORT_WINDOW = 15;
  localparam int unsigned MID_LIMIT    = 75;
  localparam int unsigned PREFIX_LIMIT = 1000;

  localparam logic [AMP_W-1:0]  LOUD_DB = AMP_W'(65);
  localparam logic [CNT_W-1:0]  MAX32   = '1;
  localparam logic [DUR_W-1:0]  MAX48   = '1;
  localparam logic [HIST_W-1:0] MAX24   = '1;
  localparam logic [HIST_W-1:0] HIST_RESET = HIST_W'(65536);

  localparam int unsigned PROD_W    = 72;
  localparam int unsigned MUL_STEPS = 36;
  localparam int unsigned DIV_STEPS = 24;
  localparam int unsigned STEP_W    = 6;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 48;
  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TEST_MODE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_DUR   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_LOUD  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_CNT   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_HOLD  = 3'd5;

endpackage

// ===== src/aehg_ram.sv =====
// generic single write port, single read port ram with registered read
// no dependencies
module aehg_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== src/acoustic_emission_hit_grader_top.sv =====
// top level of the acoustic emission hit grader: counters, top-ten list,
// energy ring and the historic index unit; uses aehg_pkg and aehg_ram
//
//   channel  | direction | handshake             | payload
//   in       | input     | in_valid_i/in_stall_o | amplitude, duration, energy, slot
//   out      | output    | out_valid_o/out_stall_i | counts, indices, limit flags
//   cfg      | input     | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i
//
// a hit runs through the states drop (ring read), mul (shift-add multiplier,
// with the mean divider alongside), prep (divider setup), div (restoring
// divider) and done (load the result register once the output register is free).
// a new hit is taken once the previous one is done and the state is back in idle;
// the result register may still wait on out_stall_i while the next hit is in work.
// reset clears all statistics counters and the top list; the ring needs no clearing.
module acoustic_emission_hit_grader_top (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [aehg_pkg::AMP_W-1:0]      amplitude_db_i,
  input  logic [31:0]                     hit_duration_i,
  input  logic [31:0]                     hit_energy_i,
  input  logic [aehg_pkg::SLOT_W-1:0]     hold_slot_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [31:0]                     counted_hits_o,
  output logic [31:0]                     loud_hits_o,
  output logic [47:0]                     duration_total_o,
  output logic [31:0]                     energy_hits_o,
  output logic [23:0]                     historic_index_o,
  output logic [31:0]                     severity_index_o,
  output logic [31:0]                     peak_hold_hits_o,
  output logic                            duration_ok_o,
  output logic                            loud_ok_o,
  output logic                            count_ok_o,
  output logic                            hold_ok_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [aehg_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [aehg_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import aehg_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_DROP = 3'd1;
  localparam logic [2:0] ST_MUL  = 3'd2;
  localparam logic [2:0] ST_PREP = 3'd3;
  localparam logic [2:0] ST_DIV  = 3'd4;
  localparam logic [2:0] ST_DONE = 3'd5;

  logic [2:0] state_q, state_d;

  // configuration
  logic [AMP_W-1:0] thr_q;
  logic             test_q;
  logic [DUR_W-1:0] max_dur_q;
  logic [CNT_W-1:0] max_loud_q, max_cnt_q, max_hold_q;

  // statistics
  logic [CNT_W-1:0]  counted_q, loud_q, peak_hold_q, ecount_q;
  logic [DUR_W-1:0]  dur_q;
  logic [CNT_W-1:0]  hold_q [HOLD_PERIODS];
  logic [63:0]       esum_q;
  logic [39:0]       wsum_q;
  logic [WIN_W-1:0]  win_q;
  logic [2:0]        mod5_q;
  logic [CNT_W-1:0]  top_q [TOP_COUNT];
  logic [TOP_CW-1:0] topn_q;
  logic [35:0]       tsum_q;
  logic [HIST_W-1:0] hpeak_q;
  logic              hist_q, drop_q;

  // arithmetic
  logic [PROD_W-1:0] a_sh_q, d_sh_q, num_q, den_q, rem_q;
  logic [31:0]       b_sh_q;
  logic [WIN_W-1:0]  w_sh_q;
  logic [23:0]       fb_q, quo_q;
  logic              sat_q;
  logic [STEP_W-1:0] cnt_q;
  logic [3:0]        sev_rem_q;
  logic [35:0]       sev_q;

  // ring
  logic               ram_we;
  logic [RING_AW-1:0] ram_waddr, ram_raddr;
  logic [31:0]        ram_rdata;

  // outputs
  logic        out_valid_q;
  logic [31:0] o_counted_q, o_loud_q, o_energy_q, o_sev_q, o_peak_q;
  logic [47:0] o_dur_q;
  logic [23:0] o_hist_q;
  logic        o_dok_q, o_lok_q, o_cok_q, o_hok_q;

  // accept-time logic
  logic                  accept, counted, energy, grow, slot_in, top_full, top_ins;
  logic [CNT_W-1:0]      n_new, hold_cur, hold_inc;
  logic [2:0]            mod5_n;
  logic [DUR_W:0]        dur_sum;
  logic [TOP_COUNT-1:0]  ge;
  logic [CNT_W-1:0]      top_new [TOP_COUNT];
  logic [HOLD_AW-1:0]    hold_idx;

  // step logic
  logic [39:0]       wsum_sub;
  logic [4:0]        sev_t;
  logic              sev_ge;
  logic [PROD_W:0]   div_t;
  logic              div_ge;
  logic [HIST_W-1:0] cand, hpeak_new;
  logic              out_free;

  assign accept      = in_valid_i & ~in_stall_o;
  assign in_stall_o  = (state_q != ST_IDLE);
  assign cfg_ready_o = 1'b1;
  assign out_free    = ~out_valid_q | ~out_stall_i;

  always_comb begin
    counted  = (amplitude_db_i >= thr_q);
    energy   = (counted | test_q) & (ecount_q != MAX32);
    n_new    = ecount_q + 32'd1;
    mod5_n   = (mod5_q == 3'd4) ? 3'd0 : mod5_q + 3'd1;
    grow     = (n_new <= CNT_W'(SHORT_WINDOW)) |
               ((n_new > CNT_W'(MID_LIMIT)) & (n_new <= CNT_W'(PREFIX_LIMIT)) &
                (mod5_n == 3'd1));
    dur_sum  = {1'b0, dur_q} + {17'd0, hit_duration_i};
    slot_in  = (hold_slot_i < SLOT_W'(HOLD_PERIODS));
    hold_idx = hold_slot_i[HOLD_AW-1:0];
    hold_cur = hold_q[hold_idx];
    hold_inc = (hold_cur == MAX32) ? hold_cur : hold_cur + 32'd1;
    for (int j = 0; j < TOP_COUNT; j++) begin
      ge[j] = (TOP_CW'(j) < topn_q) & (top_q[j] >= hit_energy_i);
    end
    top_new[0] = ge[0] ? top_q[0] : hit_energy_i;
    for (int j = 1; j < TOP_COUNT; j++) begin
      if (ge[j]) begin
        top_new[j] = top_q[j];
      end else if (ge[j-1]) begin
        top_new[j] = hit_energy_i;
      end else begin
        top_new[j] = top_q[j-1];
      end
    end
    top_full = (topn_q == TOP_CW'(TOP_COUNT));
    top_ins  = ~(top_full & ge[TOP_COUNT-1]);

    wsum_sub = wsum_q - (drop_q ? {8'd0, ram_rdata} : 40'd0);
    sev_t    = {sev_rem_q, sev_q[35]};
    sev_ge   = (sev_t >= {1'b0, topn_q});
    div_t    = {rem_q, fb_q[23]};
    div_ge   = (div_t >= {1'b0, den_q});
    cand     = sat_q ? MAX24 : quo_q;
    hpeak_new = (hist_q & (esum_q != 64'd0) & (cand > hpeak_q)) ? cand : hpeak_q;

    ram_we    = accept & energy;
    ram_waddr = ecount_q[RING_AW-1:0];
    ram_raddr = RING_AW'(ecount_q - {24'd0, win_q});

    state_d = state_q;
    case (state_q)
      ST_IDLE: if (accept) state_d = ST_DROP;
      ST_DROP: state_d = ST_MUL;
      ST_MUL:  if (cnt_q == STEP_W'(MUL_STEPS - 1)) state_d = ST_PREP;
      ST_PREP: state_d = ST_DIV;
      ST_DIV:  if (cnt_q == STEP_W'(DIV_STEPS - 1)) state_d = ST_DONE;
      ST_DONE: if (out_free) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  aehg_ram #(
    .WIDTH(32),
    .DEPTH(RING_DEPTH)
  ) u_ring (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(hit_energy_i),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  // control and statistics state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      thr_q       <= AMP_W'(40);
      test_q      <= 1'b0;
      max_dur_q   <= MAX48;
      max_loud_q  <= MAX32;
      max_cnt_q   <= MAX32;
      max_hold_q  <= MAX32;
      counted_q   <= '0;
      loud_q      <= '0;
      peak_hold_q <= '0;
      ecount_q    <= '0;
      dur_q       <= '0;
      esum_q      <= '0;
      wsum_q      <= '0;
      win_q       <= '0;
      mod5_q      <= '0;
      topn_q      <= '0;
      tsum_q      <= '0;
      hpeak_q     <= HIST_RESET;
      hist_q      <= 1'b0;
      drop_q      <= 1'b0;
      out_valid_q <= 1'b0;
      for (int j = 0; j < HOLD_PERIODS; j++) hold_q[j] <= '0;
      for (int j = 0; j < TOP_COUNT; j++) top_q[j] <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i) begin
        case (cfg_index_i)
          CFG_THRESHOLD: thr_q      <= cfg_data_i[AMP_W-1:0];
          CFG_TEST_MODE: test_q     <= cfg_data_i[0];
          CFG_MAX_DUR:   max_dur_q  <= cfg_data_i[DUR_W-1:0];
          CFG_MAX_LOUD:  max_loud_q <= cfg_data_i[CNT_W-1:0];
          CFG_MAX_CNT:   max_cnt_q  <= cfg_data_i[CNT_W-1:0];
          CFG_MAX_HOLD:  max_hold_q <= cfg_data_i[CNT_W-1:0];
          default: ;
        endcase
      end
      if (accept) begin
        hist_q <= energy;
        drop_q <= energy & ~grow;
        if (counted) begin
          if (counted_q != MAX32) counted_q <= counted_q + 32'd1;
          if ((amplitude_db_i >= LOUD_DB) && (loud_q != MAX32)) loud_q <= loud_q + 32'd1;
          dur_q <= dur_sum[DUR_W] ? MAX48 : dur_sum[DUR_W-1:0];
          if (slot_in) begin
            hold_q[hold_idx] <= hold_inc;
            if (hold_inc > peak_hold_q) peak_hold_q <= hold_inc;
          end
        end
        if (energy) begin
          ecount_q <= n_new;
          mod5_q   <= mod5_n;
          esum_q   <= esum_q + {32'd0, hit_energy_i};
          wsum_q   <= wsum_q + {8'd0, hit_energy_i};
          if (grow) win_q <= win_q + 8'd1;
          if (top_ins) begin
            for (int j = 0; j < TOP_COUNT; j++) top_q[j] <= top_new[j];
            tsum_q <= tsum_q + {4'd0, hit_energy_i} -
                      (top_full ? {4'd0, top_q[TOP_COUNT-1]} : 36'd0);
            if (!top_full) topn_q <= topn_q + 4'd1;
          end
        end
      end
      if (state_q == ST_DROP) wsum_q <= wsum_sub;
      if (state_q == ST_DONE && out_free) begin
        hpeak_q     <= hpeak_new;
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // multiplier, dividers and result register
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_DROP: begin
        a_sh_q    <= {32'd0, wsum_sub};
        b_sh_q    <= ecount_q;
        d_sh_q    <= {8'd0, esum_q};
        w_sh_q    <= win_q;
        num_q     <= '0;
        den_q     <= '0;
        cnt_q     <= '0;
        sev_rem_q <= '0;
        sev_q     <= tsum_q;
      end
      ST_MUL: begin
        if (b_sh_q[0]) num_q <= num_q + a_sh_q;
        if (w_sh_q[0]) den_q <= den_q + d_sh_q;
        a_sh_q    <= {a_sh_q[PROD_W-2:0], 1'b0};
        d_sh_q    <= {d_sh_q[PROD_W-2:0], 1'b0};
        b_sh_q    <= {1'b0, b_sh_q[31:1]};
        w_sh_q    <= {1'b0, w_sh_q[WIN_W-1:1]};
        sev_rem_q <= sev_ge ? 4'(sev_t - {1'b0, topn_q}) : sev_t[3:0];
        sev_q     <= {sev_q[34:0], sev_ge};
        cnt_q     <= cnt_q + 6'd1;
      end
      ST_PREP: begin
        // quotient fits 24 bits unless num >= den * 256
        sat_q <= ({8'd0, num_q} >= {den_q, 8'd0});
        rem_q <= {8'd0, num_q[PROD_W-1:8]};
        fb_q  <= {num_q[7:0], 16'd0};
        quo_q <= '0;
        cnt_q <= '0;
      end
      ST_DIV: begin
        rem_q <= div_ge ? PROD_W'(div_t - {1'b0, den_q}) : div_t[PROD_W-1:0];
        quo_q <= {quo_q[22:0], div_ge};
        fb_q  <= {fb_q[22:0], 1'b0};
        cnt_q <= cnt_q + 6'd1;
      end
      ST_DONE: begin
        if (out_free) begin
          o_counted_q <= counted_q;
          o_loud_q    <= loud_q;
          o_dur_q     <= dur_q;
          o_energy_q  <= ecount_q;
          o_hist_q    <= hpeak_new;
          o_sev_q     <= (topn_q == '0) ? 32'd0 : sev_q[31:0];
          o_peak_q    <= peak_hold_q;
          o_dok_q     <= (dur_q <= max_dur_q);
          o_lok_q     <= (loud_q <= max_loud_q);
          o_cok_q     <= (counted_q <= max_cnt_q);
          o_hok_q     <= (peak_hold_q <= max_hold_q);
        end
      end
      default: ;
    endcase
  end

  assign out_valid_o      = out_valid_q;
  assign counted_hits_o   = o_counted_q;
  assign loud_hits_o      = o_loud_q;
  assign duration_total_o = o_dur_q;
  assign energy_hits_o    = o_energy_q;
  assign historic_index_o = o_hist_q;
  assign severity_index_o = o_sev_q;
  assign peak_hold_hits_o = o_peak_q;
  assign duration_ok_o    = o_dok_q;
  assign loud_ok_o        = o_lok_q;
  assign count_ok_o       = o_cok_q;
  assign hold_ok_o        = o_hok_q;

endmodule
